/* rtl/ids_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_pkg
// Shared types and constants for the identifier slot table.
// ----------------------------------------------------------------------------
package ids_pkg;

    localparam int ID_W          = 64;
    localparam int OP_W          = 2;
    localparam int CNT_W         = 5;
    localparam int MAX_SLOTS_DEF = 16;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_ids_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESULT
    } t_ids_state;

    typedef struct packed {
        logic eq;
        logic zero;
    } t_ids_cmp;

    typedef struct packed {
        logic [CNT_W-1:0] slot;
        logic [CNT_W-1:0] fill;
    } t_ids_result;

endpackage

/* rtl/ids_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_cmp
// Shared identifier comparator: equality with the request and empty-slot test.
// ----------------------------------------------------------------------------
module ids_cmp (
    input  logic [ids_pkg::ID_W-1:0] i_entry,
    input  logic [ids_pkg::ID_W-1:0] i_ident,
    output ids_pkg::t_ids_cmp        o_flags
);
    import ids_pkg::*;

    assign o_flags.eq   = (i_entry == i_ident);
    assign o_flags.zero = (i_entry == '0);

endmodule

/* rtl/ids_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_seq
// Slot memory and scan sequencer: one stored entry is compared per cycle,
// then the request is resolved and the memory and fill count are updated.
// ----------------------------------------------------------------------------
module ids_seq #(
    parameter int MAX_SLOTS = ids_pkg::MAX_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ids_pkg::OP_W-1:0]   i_op,
    input  logic [ids_pkg::ID_W-1:0]   i_ident,
    input  logic [ids_pkg::CNT_W-1:0]  i_cap,
    input  logic                       i_res_ready,
    output logic                       o_busy,
    output logic                       o_res_valid,
    output ids_pkg::t_ids_result       o_res
);
    import ids_pkg::*;

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    t_ids_state            r_state, n_state;
    t_ids_op               r_op, n_op;
    logic [ID_W-1:0]       r_id, n_id;
    logic [CNT_W-1:0]      r_rd, n_rd;
    logic                  r_pend, n_pend;
    logic [CNT_W-1:0]      r_pidx, n_pidx;
    logic                  r_found, n_found;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]      r_hole, n_hole;
    logic [CNT_W-1:0]      r_fill, n_fill;
    t_ids_result           r_res, n_res;

    logic [ID_W-1:0]       mem [MAX_SLOTS];
    logic [ID_W-1:0]       r_q;
    logic                  rd_en;
    logic                  we;
    logic [CNT_W-1:0]      wslot;
    logic [ID_W-1:0]       wd;
    logic [CNT_W-1:0]      cap_eff;
    t_ids_cmp              flags;

    assign cap_eff = ({{(32-CNT_W){1'b0}}, i_cap} > 32'(MAX_SLOTS))
                     ? CNT_W'(MAX_SLOTS) : i_cap;

    ids_cmp u_cmp (
        .i_entry (r_q),
        .i_ident (r_id),
        .o_flags (flags)
    );

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_q <= mem[AW'(r_rd)];
        end
        if (we) begin
            mem[AW'(wslot)] <= wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_rd   <= n_rd;
        r_pidx <= n_pidx;
        r_idx  <= n_idx;
        r_hole <= n_hole;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_id        = r_id;
        n_rd        = r_rd;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_idx       = r_idx;
        n_hole      = r_hole;
        n_fill      = r_fill;
        n_res       = r_res;
        rd_en       = 1'b0;
        we          = 1'b0;
        wslot       = r_idx;
        wd          = r_id;
        o_busy      = 1'b1;
        o_res_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    n_op    = t_ids_op'(i_op);
                    n_id    = i_ident;
                    n_rd    = '0;
                    n_found = 1'b0;
                    n_idx   = r_fill;
                    n_hole  = r_fill;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pend && !r_found) begin
                    if (flags.eq) begin
                        n_found = 1'b1;
                        n_idx   = r_pidx;
                    end else if (flags.zero) begin
                        n_hole = r_pidx;
                    end
                end
                if (!r_found && !(r_pend && flags.eq) && (r_rd < r_fill)) begin
                    rd_en  = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_rd;
                    n_rd   = r_rd + CNT_W'(1);
                end
                if (!r_pend && (r_found || (r_rd >= r_fill))) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_res.slot = r_idx;
                case (r_op)
                    OP_INSERT: begin
                        if (r_found) begin
                            n_res.slot = r_idx;
                        end else if (r_hole < r_fill) begin
                            we         = 1'b1;
                            wslot      = r_hole;
                            n_res.slot = r_hole;
                        end else if (r_fill >= cap_eff) begin
                            n_res.slot = r_fill;
                        end else begin
                            we         = 1'b1;
                            wslot      = r_fill;
                            n_res.slot = r_fill;
                            n_fill     = r_fill + CNT_W'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            we    = 1'b1;
                            wslot = r_idx;
                            wd    = '0;
                            if (r_idx + CNT_W'(1) == r_fill) begin
                                n_fill = r_fill - CNT_W'(1);
                            end
                        end
                    end
                    default: begin
                        n_res.slot = r_idx;
                    end
                endcase
                n_res.fill = n_fill;
                n_state    = ST_RESULT;
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

/* rtl/id_slot_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_slot_table_top
// Identifier to slot table with find, insert and remove requests.
// ----------------------------------------------------------------------------
// Each item is handled on its own: after acceptance the used slots are read
// from a single-port slot memory one per cycle and checked by one shared
// comparator, then the decide state resolves the request and writes back,
// and the result state hands the result to the output register. A match
// ends the scan early; the input is stalled throughout, so a new item is
// taken only after the result of the last one is handed on. The
// capacity register resets to four and should be written only while idle.
// ----------------------------------------------------------------------------
module id_slot_table_top #(
    parameter int MAX_SLOTS = ids_pkg::MAX_SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ids_pkg::OP_W-1:0]   i_op,
    input  logic [ids_pkg::ID_W-1:0]   i_ident,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ids_pkg::CNT_W-1:0]  o_slot,
    output logic [ids_pkg::CNT_W-1:0]  o_fill_count_out,
    input  logic                       i_cfg_we,
    input  logic [ids_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import ids_pkg::*;

    logic [CNT_W-1:0]  r_cap;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_slot;
    logic [CNT_W-1:0]  r_fcnt;
    logic              busy;
    logic              res_valid;
    logic              out_free;
    t_ids_result       res;

    assign out_free = !r_out_valid || !i_out_stall;

    ids_seq #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid),
        .i_op        (i_op),
        .i_ident     (i_ident),
        .i_cap       (r_cap),
        .i_res_ready (out_free),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (res_valid && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_slot <= res.slot;
            r_fcnt <= res.fill;
        end
    end

    assign o_in_stall       = busy;
    assign o_out_valid      = r_out_valid;
    assign o_slot           = r_slot;
    assign o_fill_count_out = r_fcnt;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the identifier slot table.
// ----------------------------------------------------------------------------
// Find, insert and remove requests are sent through the valid/stall input
// channel. A predictor keeps its own copy of the slot table, the fill count
// and the capacity, and queues the expected slot and fill count for every
// accepted item. Each result taken from the output channel is compared with
// the oldest queued answer. A directed sequence covers holes, a full table,
// identifier zero, misses and the unused request code. Random phases then run
// under several capacities, from zero up to values beyond the table size,
// with random idling on both channels and a final stretch without any.
// ----------------------------------------------------------------------------
module tb_top;
    import ids_pkg::*;

    localparam int TABLE_SLOTS = MAX_SLOTS_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 8;
    localparam int SHOWN_ERRORS = 10;
    localparam int POOL_DEPTH = 32;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [OP_W-1:0]  i_op;
    logic [ID_W-1:0]  i_ident;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [CNT_W-1:0] o_slot;
    logic [CNT_W-1:0] o_fill_count_out;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    logic [ID_W-1:0]  model_ids [TABLE_SLOTS];
    logic [CNT_W-1:0] model_fill;
    logic [CNT_W-1:0] model_capacity;
    t_ids_result      slot_answers_q [$];
    logic [ID_W-1:0]  id_pool [POOL_DEPTH];

    int error_count = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit sender_idle_en = 1'b1;
    bit sender_quiet = 1'b0;
    bit receiver_stall_en = 1'b1;

    id_slot_table_top #(
        .MAX_SLOTS(TABLE_SLOTS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_ident         (i_ident),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_slot          (o_slot),
        .o_fill_count_out(o_fill_count_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Scans the used slots, then applies the request to the predicted table.
    function automatic t_ids_result table_lookup(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] ident);
        int hit;
        int hole;
        int limit;
        bit found;
        t_ids_result res;
        hit = model_fill;
        hole = model_fill;
        found = 1'b0;
        limit = (model_capacity > TABLE_SLOTS) ? TABLE_SLOTS : model_capacity;
        for (int i = 0; i < model_fill; i++) begin
            if (!found) begin
                if (model_ids[i] == ident) begin
                    hit = i;
                    found = 1'b1;
                end else if (model_ids[i] == '0) begin
                    hole = i;
                end
            end
        end
        res.slot = CNT_W'(hit);
        if (op == OP_INSERT) begin
            if (!found && hole < hit) begin
                model_ids[hole] = ident;
                res.slot = CNT_W'(hole);
            end else if (!found && hit < limit) begin
                model_ids[hit] = ident;
                model_fill = model_fill + 1'b1;
            end
        end else if (op == OP_REMOVE) begin
            if (found) begin
                model_ids[hit] = '0;
                if (hit + 1 == model_fill) begin
                    model_fill = model_fill - 1'b1;
                end
            end
        end
        res.fill = model_fill;
        return res;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("tb_top: %s", msg);
        end
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] ident);
        int gap;
        i_in_valid <= 1'b1;
        i_op <= op;
        i_ident <= ident;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        slot_answers_q.push_back(table_lookup(op, ident));
        if (sender_idle_en && !sender_quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (slot_answers_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CNT_W-1:0] cap);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_capacity = cap;
    endtask

    task automatic run_random(input int count, input int pool_n);
        logic [ID_W-1:0] ident;
        int pick;
        for (int k = 0; k < pool_n; k++) begin
            id_pool[k] = {$urandom, $urandom};
        end
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 84) begin
                ident = id_pool[$urandom_range(0, pool_n - 1)];
            end else if (pick < 92) begin
                ident = {$urandom, $urandom};
            end else if (pick < 97) begin
                ident = '0;
            end else begin
                ident = '1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_request(OP_INSERT, ident);
            end else if (pick < 70) begin
                send_request(OP_REMOVE, ident);
            end else if (pick < 95) begin
                send_request(OP_FIND, ident);
            end else begin
                send_request(OP_UNUSED, ident);
            end
        end
    endtask

    task automatic test_directed_cases();
        send_request(OP_FIND, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, 64'd1);
        send_request(OP_INSERT, 64'h8000_0000_0000_0000);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(OP_FIND, 64'd1);
        send_request(OP_UNUSED, 64'h8000_0000_0000_0000);
        send_request(OP_REMOVE, 64'd1);
        send_request(OP_FIND, '0);
        send_request(OP_INSERT, 64'h0000_1234_0000_5678);
        send_request(OP_REMOVE, 64'hA5A5_A5A5_A5A5_A5A5);
        send_request(OP_REMOVE, 64'hDEAD_BEEF_0000_0001);
        send_request(OP_INSERT, '0);
        send_request(OP_FIND, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, '1);
        send_request(OP_INSERT, '0);
        send_request(OP_FIND, 64'h7FFF_FFFF_FFFF_FFFF);
    endtask

    task automatic test_full_capacity();
        set_capacity(CNT_W'(TABLE_SLOTS));
        run_random(500, 20);
    endtask

    task automatic test_single_slot();
        set_capacity(CNT_W'(1));
        run_random(200, 4);
    endtask

    task automatic test_zero_capacity();
        set_capacity(CNT_W'(0));
        run_random(150, 6);
    endtask

    task automatic test_capacity_over_range();
        set_capacity('1);
        run_random(150, 24);
        set_capacity(CNT_W'(TABLE_SLOTS + 1));
        run_random(150, 18);
    endtask

    task automatic test_random_capacities();
        for (int r = 0; r < 8; r++) begin
            set_capacity(CNT_W'($urandom_range(0, 31)));
            run_random(60, $urandom_range(2, POOL_DEPTH));
        end
    endtask

    task automatic test_no_idling();
        set_capacity(CNT_W'(TABLE_SLOTS));
        sender_idle_en = 1'b0;
        receiver_stall_en = 1'b0;
        run_random(270, 20);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (receiver_stall_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_ids_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (slot_answers_q.size() == 0) begin
                report_error($sformatf("unexpected result slot %0d fill %0d",
                                       o_slot, o_fill_count_out));
            end else begin
                want = slot_answers_q.pop_front();
                if (o_slot !== want.slot) begin
                    report_error($sformatf("slot expected %0d actual %0d",
                                           want.slot, o_slot));
                end
                if (o_fill_count_out !== want.fill) begin
                    report_error($sformatf("fill count expected %0d actual %0d",
                                           want.fill, o_fill_count_out));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_op <= OP_FIND;
        i_ident <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= CAP_RESET;
        foreach (model_ids[i]) model_ids[i] = '0;
        model_fill = '0;
        model_capacity = CAP_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_full_capacity();
        test_single_slot();
        test_zero_capacity();
        test_capacity_over_range();
        test_random_capacities();
        test_no_idling();

        wait_idle();
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
